// File: src/cpc_pkg.sv
// Package for coprime_pair_counter: sizes, Mobius codes, FSM state type,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package cpc_pkg;

    localparam int MAX_VALUE = 65536;
    localparam int EXT_W     = 17;
    localparam int CNT_W     = 33;
    localparam int AW        = $clog2(MAX_VALUE + 1);
    localparam int CW        = AW + 1;
    localparam int DCW       = $clog2(AW + 1);

    localparam logic [1:0] MU_ZERO = 2'b00;
    localparam logic [1:0] MU_POS  = 2'b01;
    localparam logic [1:0] MU_NEG  = 2'b11;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_P_WAIT,
        ST_P_CHK,
        ST_F_RD,
        ST_F_WR,
        ST_SQ,
        ST_IDLE,
        ST_Q_RD,
        ST_Q_CHK,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic p_init;
        logic p_inc;
        logic k_init;
        logic flip_wr;
        logic sq_init;
        logic sq_wr;
        logic q_load;
        logic rd_d;
        logic d_inc;
        logic div_start;
        logic div_step;
        logic mul;
        logic acc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic k_last;
        logic p_done;
        logic p_prime;
        logic k_done;
        logic sq_done;
        logic d_done;
        logic mu_zero;
        logic div_last;
        logic out_full;
    } sts_t;

endpackage

// File: src/cpc_ctrl.sv
// Controller FSM for coprime_pair_counter: sieve sequencing and query loop.
// Depends on cpc_pkg.
module cpc_ctrl
    import cpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.k_last)
                begin
                    cmd.p_init = 1'b1;
                    state_next = ST_P_WAIT;
                end
            end
            ST_P_WAIT:
            begin
                state_next = ST_P_CHK;
            end
            ST_P_CHK:
            begin
                if (sts.p_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.p_prime)
                begin
                    cmd.k_init = 1'b1;
                    state_next = ST_F_RD;
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = ST_P_WAIT;
                end
            end
            ST_F_RD:
            begin
                if (sts.k_done)
                begin
                    cmd.sq_init = 1'b1;
                    state_next  = ST_SQ;
                end
                else
                begin
                    state_next = ST_F_WR;
                end
            end
            ST_F_WR:
            begin
                cmd.flip_wr = 1'b1;
                state_next  = ST_F_RD;
            end
            ST_SQ:
            begin
                if (sts.sq_done)
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = ST_P_WAIT;
                end
                else
                begin
                    cmd.sq_wr = 1'b1;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.q_load = 1'b1;
                    state_next = ST_Q_RD;
                end
            end
            ST_Q_RD:
            begin
                cmd.rd_d = 1'b1;
                if (sts.d_done)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_Q_CHK;
                end
            end
            ST_Q_CHK:
            begin
                cmd.rd_d = 1'b1;
                if (sts.mu_zero)
                begin
                    cmd.d_inc  = 1'b1;
                    state_next = ST_Q_RD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                cmd.d_inc  = 1'b1;
                state_next = ST_Q_RD;
            end
            ST_FIN:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

endmodule

// File: src/cpc_datapath.sv
// Datapath for coprime_pair_counter: Mobius and composite tables, sieve
// counters, two-lane restoring divider, multiplier, accumulator, result word.
// Depends on cpc_pkg.
module cpc_datapath
    import cpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [EXT_W-1:0]   extent_a,
    input  logic [EXT_W-1:0]   extent_b,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [CNT_W-1:0]   visible_count
);

    logic [1:0] mu_mem   [0:MAX_VALUE];
    logic       comp_mem [0:MAX_VALUE];

    logic [1:0]      mu_rd_reg;
    logic            comp_rd_reg;
    logic [CW-1:0]   k_reg;
    logic [CW-1:0]   p_reg;
    logic [CW-1:0]   sq_reg;
    logic [CW-1:0]   pp_reg;
    logic [CW-1:0]   d_reg;
    logic [AW-1:0]   n_reg;
    logic [AW-1:0]   m_reg;
    logic [AW-1:0]   lim_reg;
    logic [AW-1:0]   dva_reg;
    logic [AW-1:0]   dvb_reg;
    logic [CW-1:0]   ra_reg;
    logic [CW-1:0]   rb_reg;
    logic [AW-1:0]   qa_reg;
    logic [AW-1:0]   qb_reg;
    logic [AW-1:0]   dvs_reg;
    logic [DCW-1:0]  cnt_reg;
    logic            neg_reg;
    logic [CNT_W-1:0] prod_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] count_reg;
    logic            valid_reg;

    logic [AW-1:0]   n_clamp;
    logic [AW-1:0]   m_clamp;
    logic [2*CW-1:0] pp_full;
    logic [AW-1:0]   mu_raddr;
    logic [CW-1:0]   ta;
    logic [CW-1:0]   tb;
    logic            ga;
    logic            gb;
    logic [CNT_W-1:0] axis;

    assign n_clamp  = (32'(extent_a) > 32'(MAX_VALUE)) ? AW'(MAX_VALUE) : AW'(extent_a);
    assign m_clamp  = (32'(extent_b) > 32'(MAX_VALUE)) ? AW'(MAX_VALUE) : AW'(extent_b);
    assign pp_full  = p_reg * p_reg;
    assign mu_raddr = cmd.rd_d ? d_reg[AW-1:0] : k_reg[AW-1:0];
    assign ta       = {ra_reg[CW-2:0], dva_reg[AW-1]};
    assign tb       = {rb_reg[CW-2:0], dvb_reg[AW-1]};
    assign ga       = ta >= {1'b0, dvs_reg};
    assign gb       = tb >= {1'b0, dvs_reg};
    assign axis     = CNT_W'(n_reg != '0) + CNT_W'(m_reg != '0);

    assign sts.k_last   = k_reg == CW'(MAX_VALUE);
    assign sts.p_done   = p_reg > CW'(MAX_VALUE);
    assign sts.p_prime  = !comp_rd_reg;
    assign sts.k_done   = k_reg > CW'(MAX_VALUE);
    assign sts.sq_done  = sq_reg > CW'(MAX_VALUE);
    assign sts.d_done   = d_reg > {1'b0, lim_reg};
    assign sts.mu_zero  = mu_rd_reg == MU_ZERO;
    assign sts.div_last = cnt_reg == DCW'(1);
    assign sts.out_full = valid_reg && rsp_stall;

    assign rsp_valid     = valid_reg;
    assign visible_count = count_reg;

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            mu_mem[k_reg[AW-1:0]]   <= MU_POS;
            comp_mem[k_reg[AW-1:0]] <= 1'b0;
        end
        else if (cmd.flip_wr)
        begin
            mu_mem[k_reg[AW-1:0]] <= 2'(~mu_rd_reg + 2'd1);
            if (k_reg != p_reg)
            begin
                comp_mem[k_reg[AW-1:0]] <= 1'b1;
            end
        end
        else if (cmd.sq_wr)
        begin
            mu_mem[sq_reg[AW-1:0]] <= MU_ZERO;
        end
        mu_rd_reg   <= mu_mem[mu_raddr];
        comp_rd_reg <= comp_mem[p_reg[AW-1:0]];
    end

    // sieve and query counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            p_reg  <= '0;
            sq_reg <= '0;
            pp_reg <= '0;
            d_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                k_reg <= k_reg + CW'(1);
            end
            else if (cmd.k_init)
            begin
                k_reg <= p_reg;
            end
            else if (cmd.flip_wr)
            begin
                k_reg <= k_reg + p_reg;
            end
            if (cmd.p_init)
            begin
                p_reg <= CW'(2);
            end
            else if (cmd.p_inc)
            begin
                p_reg <= p_reg + CW'(1);
            end
            if (cmd.sq_init)
            begin
                if (pp_full > (2*CW)'(MAX_VALUE))
                begin
                    sq_reg <= CW'(MAX_VALUE + 1);
                    pp_reg <= CW'(MAX_VALUE + 1);
                end
                else
                begin
                    sq_reg <= pp_full[CW-1:0];
                    pp_reg <= pp_full[CW-1:0];
                end
            end
            else if (cmd.sq_wr)
            begin
                sq_reg <= sq_reg + pp_reg;
            end
            if (cmd.q_load)
            begin
                d_reg <= CW'(1);
            end
            else if (cmd.d_inc)
            begin
                d_reg <= d_reg + CW'(1);
            end
        end
    end

    // query operands, divider, product, accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            n_reg   <= n_clamp;
            m_reg   <= m_clamp;
            lim_reg <= (n_clamp < m_clamp) ? n_clamp : m_clamp;
            acc_reg <= '0;
        end
        if (cmd.div_start)
        begin
            dva_reg <= n_reg;
            dvb_reg <= m_reg;
            ra_reg  <= '0;
            rb_reg  <= '0;
            dvs_reg <= d_reg[AW-1:0];
            neg_reg <= mu_rd_reg == MU_NEG;
        end
        else if (cmd.div_step)
        begin
            dva_reg <= dva_reg << 1;
            dvb_reg <= dvb_reg << 1;
            ra_reg  <= ga ? (ta - {1'b0, dvs_reg}) : ta;
            rb_reg  <= gb ? (tb - {1'b0, dvs_reg}) : tb;
            qa_reg  <= {qa_reg[AW-2:0], ga};
            qb_reg  <= {qb_reg[AW-2:0], gb};
        end
        if (cmd.mul)
        begin
            prod_reg <= CNT_W'(qa_reg * qb_reg);
        end
        if (cmd.acc)
        begin
            acc_reg <= neg_reg ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
        end
        if (cmd.out_load)
        begin
            count_reg <= acc_reg + axis;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                cnt_reg <= DCW'(AW);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - DCW'(1);
            end
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> cnt_reg == '0)
        else $error("product taken before divider finished");
    a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |-> $past(cmd.mul))
        else $error("accumulate without fresh product");
    a_div_nonzero_mu: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> mu_rd_reg != MU_ZERO)
        else $error("divider started on zero Mobius term");
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(valid_reg && rsp_stall))
        else $error("result word overwritten");
`endif

endmodule

// File: src/coprime_pair_counter.sv
// channel  dir  handshake             payload
// req      in   req_valid/req_stall   extent_a[16:0], extent_b[16:0]
// rsp      out  rsp_valid/rsp_stall   visible_count[32:0]
// After reset a clear pass writes all MAX_VALUE+1 table entries, then the sieve reads and
// checks each candidate p, reads and rewrites each multiple of a prime, and zeroes each
// multiple of its square. req_stall stays high until the sieve ends.
// A query walks d up to min(n,m); each nonzero Mobius term runs the 17-step divider.
// One query at a time; the result word waits under rsp_stall.
// Depends on cpc_pkg, cpc_ctrl, cpc_datapath.
module coprime_pair_counter
    import cpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [EXT_W-1:0] extent_a,
    input  logic [EXT_W-1:0] extent_b,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [CNT_W-1:0] visible_count
);

    cmd_t cmd;
    sts_t sts;

    cpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .extent_a      (extent_a),
        .extent_b      (extent_b),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .visible_count (visible_count)
    );

endmodule

// File: dv/cpc_checker.sv
`timescale 1ns / 1ps
// Checker for coprime_pair_counter: watches the req and rsp channels and predicts
// each count from its own Mobius sieve. It compares every result in order.
// Depends on cpc_pkg.
module cpc_checker
    import cpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_stall,
    input  logic [EXT_W-1:0] extent_a,
    input  logic [EXT_W-1:0] extent_b,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  logic [CNT_W-1:0] visible_count,
    output int               mismatches,
    output int               pending,
    output int               results_seen
);

    byte            mu_of[0:MAX_VALUE];
    bit             is_composite[0:MAX_VALUE];
    logic [CNT_W-1:0] count_queue[$];

    initial
    begin
        longint sq;
        for (int k = 0; k <= MAX_VALUE; k++)
        begin
            mu_of[k] = (k == 0) ? 8'sd0 : 8'sd1;
            is_composite[k] = 1'b0;
        end
        for (int p = 2; p <= MAX_VALUE; p++)
        begin
            if (!is_composite[p])
            begin
                for (int k = p; k <= MAX_VALUE; k += p)
                begin
                    if (k != p)
                        is_composite[k] = 1'b1;
                    mu_of[k] = -mu_of[k];
                end
                for (sq = longint'(p) * p; sq <= MAX_VALUE; sq += longint'(p) * p)
                    mu_of[sq] = 8'sd0;
            end
        end
    end

    function automatic logic [CNT_W-1:0] visible_points(logic [EXT_W-1:0] a,
                                                        logic [EXT_W-1:0] b);
        longint n;
        longint m;
        longint lim;
        longint acc;
        n = (a > MAX_VALUE) ? longint'(MAX_VALUE) : longint'(a);
        m = (b > MAX_VALUE) ? longint'(MAX_VALUE) : longint'(b);
        lim = (n < m) ? n : m;
        acc = 0;
        for (longint d = 1; d <= lim; d++)
            if (mu_of[d] != 0)
                acc += mu_of[d] * (n / d) * (m / d);
        acc += longint'(n != 0) + longint'(m != 0);
        return acc[CNT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatches   <= 0;
            results_seen <= 0;
            pending      <= 0;
            count_queue.delete();
        end
        else
        begin
            if (req_valid && !req_stall)
                count_queue = {count_queue, visible_points(extent_a, extent_b)};
            if (rsp_valid && !rsp_stall)
            begin
                results_seen <= results_seen + 1;
                if (count_queue.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word: visible_count=%0d", visible_count);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    logic [CNT_W-1:0] want;
                    want = count_queue.pop_front();
                    if (visible_count !== want)
                    begin
                        if (mismatches < 10)
                            $display("visible_count mismatch: expected %0d, got %0d",
                                     want, visible_count);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= count_queue.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for coprime_pair_counter: clock, reset, query stimulus and the
// receiver stall. Depends on cpc_pkg, coprime_pair_counter and cpc_checker.
module tb;
    import cpc_pkg::*;

    localparam longint CYCLE_LIMIT = 30000000;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [EXT_W-1:0] extent_a;
    logic [EXT_W-1:0] extent_b;
    logic             rsp_valid;
    logic             rsp_stall;
    logic [CNT_W-1:0] visible_count;
    int               mismatches;
    int               pending;
    int               results_seen;
    int               send_idle_pct;
    int               recv_idle_pct;
    longint           cycles;

    coprime_pair_counter dut (.*);

    cpc_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic send_query(logic [EXT_W-1:0] a, logic [EXT_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        extent_a  <= a;
        extent_b  <= b;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic send_random;
        logic [EXT_W-1:0] big;
        logic [EXT_W-1:0] narrow;
        big = EXT_W'($urandom_range(0, (1 << EXT_W) - 1));
        if ($urandom_range(9) == 0)
            narrow = EXT_W'($urandom_range(0, 2000));
        else if ($urandom_range(9) == 0)
            narrow = '0;
        else
            narrow = EXT_W'($urandom_range(0, 200));
        if ($urandom_range(1))
            send_query(big, narrow);
        else
            send_query(narrow, big);
    endtask

    initial
    begin
        req_valid     = 1'b0;
        extent_a      = '0;
        extent_b      = '0;
        send_idle_pct = 14;
        recv_idle_pct = 66;
        @(posedge rst_n);
        @(posedge clk);

        send_query(EXT_W'(0), EXT_W'(0));
        send_query(EXT_W'(0), EXT_W'(5));
        send_query(EXT_W'(5), EXT_W'(0));
        send_query(EXT_W'(1), EXT_W'(1));
        send_query(EXT_W'(1), 17'h1FFFF);
        send_query(17'h1FFFF, EXT_W'(1));
        send_query(EXT_W'(65536), EXT_W'(3));
        send_query(EXT_W'(65537), EXT_W'(2));
        send_query(EXT_W'(2), EXT_W'(65535));
        send_query(EXT_W'(7), EXT_W'(100));
        send_query(EXT_W'(100), EXT_W'(7));
        send_query(17'h15555, 17'h0AAAA & 17'h000FF);
        send_query(EXT_W'(65536), 17'h1FFFF);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < 33; i++)
            send_random();
        send_idle_pct = 66;
        recv_idle_pct = 14;
        for (int i = 0; i < 33; i++)
            send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 34; i++)
            send_random();
        req_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Ran %0d queries: saturated, zero and full extents, then random extents",
                 results_seen);
        $display("under three sender/receiver stall mixes; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/cpc_pkg.sv
src/cpc_ctrl.sv
src/cpc_datapath.sv
src/coprime_pair_counter.sv
dv/cpc_checker.sv
dv/tb.sv
